@@ sv/ekv_pkg.sv @@
// Shared types, codes, constants and byte helpers of the key/value dictionary.
`timescale 1ns / 1ps
`default_nettype none
package ekv_pkg;

   localparam int STORE_BYTES_DEF = 4096;
   localparam int KEY_BYTES_DEF   = 32;

   localparam logic [2:0] CMD_CLEAR = 3'd0;
   localparam logic [2:0] CMD_RAW   = 3'd1;
   localparam logic [2:0] CMD_KEY   = 3'd2;
   localparam logic [2:0] CMD_VAL   = 3'd3;
   localparam logic [2:0] CMD_ADD   = 3'd4;
   localparam logic [2:0] CMD_LOOK  = 3'd5;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_CR  = 8'd13;
   localparam logic [7:0] CH_LF  = 8'd10;
   localparam logic [7:0] CH_EQ  = 8'h3d;  // '='
   localparam logic [7:0] CH_BSL = 8'h5c;  // backslash
   localparam logic [7:0] CH_E   = 8'h65;  // 'e'
   localparam logic [7:0] CH_R   = 8'h72;  // 'r'
   localparam logic [7:0] CH_N   = 8'h6e;  // 'n'
   localparam logic [7:0] CH_0   = 8'h30;  // '0'

   localparam logic [6:0] LIM_MAX = 7'd64;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_NO_ROOM   = 2'd2,
      ST_KEY_LONG  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE, S_RAW2, S_FIND, S_FIND_CHK, S_NEXT, S_KWAIT,
      S_PUT, S_PUT2, S_DONE, S_LK_RD, S_LK_CHK
   } eng_state_type;

   typedef enum logic [2:0] {
      PH_LF, PH_KEY, PH_VAL, PH_ESC, PH_END
   } phase_type;

   typedef enum logic [1:0] {
      LM_MATCH, LM_SKIP, LM_VALUE
   } scan_mode_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] value_byte;
      logic [5:0] value_length;
      status_type status;
      logic       last;
   } rsp_beat_type;

   function automatic logic is_special(input logic [7:0] b);
      return (b == CH_NUL) || (b == CH_CR) || (b == CH_LF) || (b == CH_BSL) || (b == CH_EQ);
   endfunction

   function automatic logic [7:0] esc_code(input logic [7:0] b);
      logic [7:0] r;
      r = CH_BSL;
      if (b == CH_NUL)     r = CH_0;
      else if (b == CH_CR) r = CH_R;
      else if (b == CH_LF) r = CH_N;
      else if (b == CH_EQ) r = CH_E;
      return r;
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c == CH_R)      r = CH_CR;
      else if (c == CH_N) r = CH_LF;
      else if (c == CH_0) r = CH_NUL;
      else if (c == CH_E) r = CH_EQ;
      return r;
   endfunction

endpackage
`default_nettype wire

@@ sv/ekv_ram.sv @@
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module ekv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

@@ sv/ekv_engine.sv @@
// Command sequencer: store append, add with escaping, and line-by-line lookup.
`timescale 1ns / 1ps
`default_nettype none
module ekv_engine #(
   parameter int STORE_BYTES = ekv_pkg::STORE_BYTES_DEF,
   parameter int KEY_BYTES   = ekv_pkg::KEY_BYTES_DEF,
   localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1,
   localparam int PW  = $clog2(STORE_BYTES + 1),
   localparam int KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1,
   localparam int KCW = $clog2(KEY_BYTES + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [2:0]           req_command,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 csr_we,
   input  wire logic [6:0]           csr_wdata,
   output ekv_pkg::rsp_beat_type     rsp,
   output logic                      st_we,
   output logic [AW-1:0]             st_waddr,
   output logic [7:0]                st_wdata,
   output logic [AW-1:0]             st_raddr,
   input  wire logic [7:0]           st_rdata,
   output logic                      k_we,
   output logic [KIW-1:0]            k_waddr,
   output logic [7:0]                k_wdata,
   output logic [KIW-1:0]            k_raddr,
   input  wire logic [7:0]           k_rdata
);
   import ekv_pkg::*;

   localparam logic [PW-1:0]  STORE_P  = PW'(STORE_BYTES);
   localparam logic [PW-1:0]  STORE_M1 = PW'(STORE_BYTES - 1);
   localparam logic [PW-1:0]  ONE_P    = PW'(1);
   localparam logic [KCW-1:0] KEY_N    = KCW'(KEY_BYTES);
   localparam logic [KCW-1:0] ONE_K    = KCW'(1);

   eng_state_type state_ff, state_in;
   phase_type     phase_ff, phase_in;
   scan_mode_type mode_ff, mode_in;
   logic [2:0]     cmd_ff, cmd_in;
   logic [7:0]     byte_ff, byte_in;
   logic [7:0]     pb_ff, pb_in;
   logic           esc_ff, esc_in;
   logic [PW-1:0]  tend_ff, tend_in;
   logic [PW-1:0]  fill_ff, fill_in;
   logic [PW-1:0]  awp_ff, awp_in;
   logic [PW-1:0]  astart_ff, astart_in;
   logic [PW-1:0]  ptr_ff, ptr_in;
   logic           started_ff, started_in;
   logic           failed_ff, failed_in;
   logic [KCW-1:0] kc_ff, kc_in;
   logic [KCW-1:0] kidx_ff, kidx_in;
   logic           kovf_ff, kovf_in;
   logic [5:0]     vcnt_ff, vcnt_in;
   logic [6:0]     mvl_ff, mvl_in;
   logic           rdok_ff;
   rsp_beat_type   rsp_ff, rsp_in;

   logic [6:0]    lim;
   logic [7:0]    cur;
   logic [PW-1:0] ptr_nx;
   logic          ptr_end;
   logic          wr_en;
   logic [PW-1:0] wr_pos;
   logic [PW-1:0] wr_top;
   logic [7:0]    wr_byte;
   logic          key_take;
   logic          adv, found, nf, emit;
   logic [7:0]    eb;

   assign lim      = (mvl_ff > LIM_MAX) ? LIM_MAX : mvl_ff;
   assign cur      = rdok_ff ? st_rdata : CH_NUL;
   assign ptr_nx   = ptr_ff + ONE_P;
   assign ptr_end  = (ptr_nx >= STORE_P);
   assign key_take = !started_ff && (req_data_byte != CH_NUL);
   assign wr_top   = wr_pos + ONE_P;

   assign busy     = (state_ff != S_IDLE);
   assign rsp      = rsp_ff;
   assign st_we    = wr_en;
   assign st_waddr = wr_pos[AW-1:0];
   assign st_wdata = wr_byte;
   assign st_raddr = ptr_ff[AW-1:0];
   assign k_waddr  = kc_ff[KIW-1:0];
   assign k_wdata  = req_data_byte;
   assign k_raddr  = kidx_ff[KIW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         tend_ff    <= '0;
         fill_ff    <= '0;
         awp_ff     <= '0;
         astart_ff  <= '0;
         started_ff <= 1'b0;
         failed_ff  <= 1'b0;
         kc_ff      <= '0;
         kovf_ff    <= 1'b0;
         mvl_ff     <= LIM_MAX;
         rsp_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         tend_ff    <= tend_in;
         fill_ff    <= fill_in;
         awp_ff     <= awp_in;
         astart_ff  <= astart_in;
         started_ff <= started_in;
         failed_ff  <= failed_in;
         kc_ff      <= kc_in;
         kovf_ff    <= kovf_in;
         mvl_ff     <= mvl_in;
         rsp_ff     <= rsp_in;
      end
      phase_ff <= phase_in;
      mode_ff  <= mode_in;
      cmd_ff   <= cmd_in;
      byte_ff  <= byte_in;
      pb_ff    <= pb_in;
      esc_ff   <= esc_in;
      ptr_ff   <= ptr_in;
      kidx_ff  <= kidx_in;
      vcnt_ff  <= vcnt_in;
      rdok_ff  <= (ptr_ff < fill_ff);
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      mode_in    = mode_ff;
      cmd_in     = cmd_ff;
      byte_in    = byte_ff;
      pb_in      = pb_ff;
      esc_in     = esc_ff;
      tend_in    = tend_ff;
      fill_in    = fill_ff;
      awp_in     = awp_ff;
      astart_in  = astart_ff;
      ptr_in     = ptr_ff;
      started_in = started_ff;
      failed_in  = failed_ff;
      kc_in      = kc_ff;
      kidx_in    = kidx_ff;
      kovf_in    = kovf_ff;
      vcnt_in    = vcnt_ff;
      mvl_in     = csr_we ? csr_wdata : mvl_ff;
      rsp_in     = '0;
      wr_en      = 1'b0;
      wr_pos     = awp_ff;
      wr_byte    = CH_NUL;
      k_we       = 1'b0;
      adv        = 1'b0;
      found      = 1'b0;
      nf         = 1'b0;
      emit       = 1'b0;
      eb         = cur;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in  = req_command;
               byte_in = req_data_byte;
               rsp_in.valid  = 1'b1;
               rsp_in.last   = 1'b1;
               rsp_in.status = ST_OK;
               unique case (req_command)
                  CMD_CLEAR: begin
                     fill_in    = '0;
                     tend_in    = '0;
                     awp_in     = '0;
                     astart_in  = '0;
                     started_in = 1'b0;
                     failed_in  = 1'b0;
                     kc_in      = '0;
                     kovf_in    = 1'b0;
                  end
                  CMD_RAW: begin
                     if (!started_ff && (tend_ff < STORE_M1)) begin
                        wr_en        = 1'b1;
                        wr_pos       = tend_ff;
                        wr_byte      = req_data_byte;
                        tend_in      = tend_ff + ONE_P;
                        rsp_in.valid = 1'b0;
                        state_in     = S_RAW2;
                     end
                  end
                  CMD_KEY: begin
                     if (key_take && (kc_ff < KEY_N)) begin
                        k_we  = 1'b1;
                        kc_in = kc_ff + ONE_K;
                     end else if (key_take) begin
                        kovf_in = 1'b1;
                     end
                     if (kovf_ff || (key_take && (kc_ff >= KEY_N))) begin
                        rsp_in.status = ST_KEY_LONG;
                     end
                  end
                  CMD_VAL, CMD_ADD: begin
                     if (kovf_ff) begin
                        rsp_in.status = ST_KEY_LONG;
                        if (req_command == CMD_ADD) begin
                           started_in = 1'b0;
                           failed_in  = 1'b0;
                           kc_in      = '0;
                           kovf_in    = 1'b0;
                        end
                     end else if (!started_ff) begin
                        rsp_in.valid = 1'b0;
                        started_in   = 1'b1;
                        failed_in    = 1'b0;
                        ptr_in       = '0;
                        state_in     = S_FIND;
                     end else begin
                        rsp_in.valid = 1'b0;
                        phase_in     = PH_VAL;
                        state_in     = S_NEXT;
                     end
                  end
                  CMD_LOOK: begin
                     if (kovf_ff) begin
                        rsp_in.status = ST_KEY_LONG;
                        kc_in   = '0;
                        kovf_in = 1'b0;
                     end else if (lim == 7'd0) begin
                        rsp_in.status = ST_NOT_FOUND;
                        kc_in   = '0;
                        kovf_in = 1'b0;
                     end else begin
                        rsp_in.valid = 1'b0;
                        ptr_in       = '0;
                        kidx_in      = '0;
                        vcnt_in      = '0;
                        mode_in      = LM_MATCH;
                        state_in     = S_LK_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_RAW2: begin
            wr_en         = 1'b1;
            wr_pos        = tend_ff;
            rsp_in.valid  = 1'b1;
            rsp_in.last   = 1'b1;
            rsp_in.status = ST_OK;
            state_in      = S_IDLE;
         end

         S_FIND: begin
            state_in = S_FIND_CHK;
         end

         S_FIND_CHK: begin
            if (cur != CH_NUL) begin
               if (ptr_end) begin
                  failed_in = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  ptr_in   = ptr_nx;
                  state_in = S_FIND;
               end
            end else begin
               astart_in = ptr_ff;
               awp_in    = ptr_ff;
               kidx_in   = '0;
               phase_in  = (ptr_ff != '0) ? PH_LF : PH_KEY;
               state_in  = S_NEXT;
            end
         end

         S_NEXT: begin
            if (failed_ff) begin
               state_in = S_DONE;
            end else begin
               unique case (phase_ff)
                  PH_LF: begin
                     pb_in    = CH_LF;
                     phase_in = PH_KEY;
                     state_in = S_PUT;
                  end
                  PH_KEY: begin
                     if (kidx_ff < kc_ff) begin
                        kidx_in  = kidx_ff + ONE_K;
                        state_in = S_KWAIT;
                     end else begin
                        pb_in    = CH_EQ;
                        phase_in = PH_VAL;
                        state_in = S_PUT;
                     end
                  end
                  PH_VAL: begin
                     if (cmd_ff == CMD_VAL) begin
                        if (is_special(byte_ff)) begin
                           pb_in    = CH_BSL;
                           phase_in = PH_ESC;
                        end else begin
                           pb_in    = byte_ff;
                           phase_in = PH_END;
                        end
                        state_in = S_PUT;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
                  PH_ESC: begin
                     pb_in    = esc_code(byte_ff);
                     phase_in = PH_END;
                     state_in = S_PUT;
                  end
                  PH_END: begin
                     state_in = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_KWAIT: begin
            pb_in    = k_rdata;
            state_in = S_PUT;
         end

         S_PUT: begin
            wr_en    = 1'b1;
            wr_pos   = awp_ff;
            wr_byte  = pb_ff;
            awp_in   = awp_ff + ONE_P;
            state_in = S_PUT2;
         end

         S_PUT2: begin
            wr_en = 1'b1;
            if (awp_ff >= STORE_P) begin
               // ran off the end: cut the entry back to its start
               wr_pos    = astart_ff;
               tend_in   = astart_ff;
               failed_in = 1'b1;
            end else begin
               wr_pos = awp_ff;
            end
            state_in = S_NEXT;
         end

         S_DONE: begin
            rsp_in.valid  = 1'b1;
            rsp_in.last   = 1'b1;
            rsp_in.status = failed_ff ? ST_NO_ROOM : ST_OK;
            if (cmd_ff != CMD_VAL) begin
               if (!failed_ff) begin
                  tend_in = awp_ff;
               end
               started_in = 1'b0;
               failed_in  = 1'b0;
               kc_in      = '0;
               kovf_in    = 1'b0;
            end
            state_in = S_IDLE;
         end

         S_LK_RD: begin
            state_in = S_LK_CHK;
         end

         S_LK_CHK: begin
            unique case (mode_ff)
               LM_MATCH: begin
                  if (cur == CH_NUL) begin
                     nf = 1'b1;
                  end else if ((kidx_ff < kc_ff) && (cur == k_rdata)) begin
                     kidx_in = kidx_ff + ONE_K;
                     adv     = 1'b1;
                  end else if ((kidx_ff == kc_ff) && (cur == CH_EQ)) begin
                     mode_in = LM_VALUE;
                     vcnt_in = '0;
                     esc_in  = 1'b0;
                     adv     = 1'b1;
                  end else if ((cur == CH_CR) || (cur == CH_LF)) begin
                     kidx_in = '0;
                     adv     = 1'b1;
                  end else begin
                     mode_in = LM_SKIP;
                     adv     = 1'b1;
                  end
               end
               LM_SKIP: begin
                  if (cur == CH_NUL) begin
                     nf = 1'b1;
                  end else if ((cur == CH_CR) || (cur == CH_LF)) begin
                     mode_in = LM_MATCH;
                     kidx_in = '0;
                     adv     = 1'b1;
                  end else begin
                     adv = 1'b1;
                  end
               end
               LM_VALUE: begin
                  if ((cur == CH_NUL) || (cur == CH_CR) || (cur == CH_LF)) begin
                     found = 1'b1;
                  end else begin
                     if (esc_ff) begin
                        esc_in = 1'b0;
                        emit   = 1'b1;
                        eb     = unescape(cur);
                     end else if (cur == CH_BSL) begin
                        esc_in = 1'b1;
                     end else begin
                        emit = 1'b1;
                     end
                     if (emit && ({1'b0, vcnt_ff} == (lim - 7'd1))) begin
                        found = 1'b1;
                     end else begin
                        if (emit) begin
                           rsp_in.valid      = 1'b1;
                           rsp_in.value_byte = eb;
                           vcnt_in           = vcnt_ff + 6'd1;
                        end
                        adv = 1'b1;
                     end
                  end
               end
               default: begin
                  nf = 1'b1;
               end
            endcase

            if (adv) begin
               if (ptr_end) begin
                  nf = 1'b1;
               end else begin
                  ptr_in   = ptr_nx;
                  state_in = S_LK_RD;
               end
            end
            if (found || nf) begin
               rsp_in.valid        = 1'b1;
               rsp_in.last         = 1'b1;
               rsp_in.value_byte   = CH_NUL;
               rsp_in.value_length = found ? vcnt_ff : 6'd0;
               rsp_in.status       = found ? ST_OK : ST_NOT_FOUND;
               kc_in               = '0;
               kovf_in             = 1'b0;
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (wr_en && (wr_top > fill_ff)) begin
         fill_in = wr_top;
      end
   end

endmodule
`default_nettype wire

@@ sv/escaped_key_value_dictionary_top.sv @@
// Top level of the escaped key/value dictionary: sequencer plus text and key memories.
//
//  channel   ports                                            handshake
//  request   req_command, req_data_byte                       start & !busy
//  response  rsp_value_byte, rsp_value_length, rsp_status,    rsp_valid, one cycle
//            rsp_last
//  csr       csr_wdata (max_value_length)                     csr_we
//
// Clear, key byte, refused raw byte, key-too-long and lookup rejects, unused codes:
// beat registered from the idle state. Raw load: byte write, then terminator write.
// Value byte / commit: each text byte is written through the single store write port,
// then its terminator; the first one of an entry first walks the store, reading and
// checking each byte, to find the end of text, then writes the key and the separator.
// Lookup: each store byte walked is read, then checked, with no overlap; value beats
// come out at most one per store byte walked.
// Reset is synchronous; a fill count stands in for clearing the store, so no
// clearing sweep is needed. The receiver cannot stall: every beat is a strobe.
`timescale 1ns / 1ps
`default_nettype none
module escaped_key_value_dictionary_top #(
   parameter int STORE_BYTES = ekv_pkg::STORE_BYTES_DEF,
   parameter int KEY_BYTES   = ekv_pkg::KEY_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [2:0] req_command,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       csr_we,
   input  wire logic [6:0] csr_wdata,
   output logic            rsp_valid,
   output logic [7:0]      rsp_value_byte,
   output logic [5:0]      rsp_value_length,
   output logic [1:0]      rsp_status,
   output logic            rsp_last
);
   import ekv_pkg::*;

   localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int KIW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

   rsp_beat_type   rsp;

   // text store port
   logic           st_we;
   logic [AW-1:0]  st_waddr;
   logic [7:0]     st_wdata;
   logic [AW-1:0]  st_raddr;
   logic [7:0]     st_rdata;

   // key buffer port
   logic           k_we;
   logic [KIW-1:0] k_waddr;
   logic [7:0]     k_wdata;
   logic [KIW-1:0] k_raddr;
   logic [7:0]     k_rdata;

   ekv_engine #(
      .STORE_BYTES (STORE_BYTES),
      .KEY_BYTES   (KEY_BYTES)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_data_byte (req_data_byte),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .rsp           (rsp),
      .st_we         (st_we),
      .st_waddr      (st_waddr),
      .st_wdata      (st_wdata),
      .st_raddr      (st_raddr),
      .st_rdata      (st_rdata),
      .k_we          (k_we),
      .k_waddr       (k_waddr),
      .k_wdata       (k_wdata),
      .k_raddr       (k_raddr),
      .k_rdata       (k_rdata)
   );

   // newline-separated key=value text, zero-terminated
   ekv_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_text_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (st_waddr),
      .wdata (st_wdata),
      .raddr (st_raddr),
      .rdata (st_rdata)
   );

   // key under construction; only entries below the key count are read
   ekv_ram #(
      .WIDTH (8),
      .DEPTH (KEY_BYTES)
   ) u_key_ram (
      .clock (clock),
      .we    (k_we),
      .waddr (k_waddr),
      .wdata (k_wdata),
      .raddr (k_raddr),
      .rdata (k_rdata)
   );

   assign rsp_valid        = rsp.valid;
   assign rsp_value_byte   = rsp.value_byte;
   assign rsp_value_length = rsp.value_length;
   assign rsp_status       = rsp.status;
   assign rsp_last         = rsp.last;

endmodule
`default_nettype wire

@@ sv/ekv_checker.sv @@
// Port-level assertions for the dictionary top level, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module ekv_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [2:0] req_command,
   input wire logic       rsp_valid,
   input wire logic [7:0] rsp_value_byte,
   input wire logic [5:0] rsp_value_length,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_last
);
   import ekv_pkg::*;

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("busy or beat right after reset");

   a_data_beat_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == ST_OK && rsp_value_length == 6'd0))
      else $error("value beat carries status or length");

   a_close_no_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_value_byte == 8'h00))
      else $error("closing beat carries a value byte");

   a_quick_cmds: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == CMD_CLEAR || req_command == CMD_KEY))
      |=> (rsp_valid && rsp_last && !busy))
      else $error("clear or key byte did not close in one cycle");

   a_fail_len_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_last && rsp_value_length == 6'd0))
      else $error("failing beat not a zero-length close");

endmodule

bind escaped_key_value_dictionary_top ekv_checker u_ekv_checker (.*);
`default_nettype wire
